// ----- sv/rtcep_pkg.sv -----
package rtcep_pkg;

	localparam int CY_W   = 12;
	localparam int YEAR_W = 13;
	localparam int CENT_W = 6;

	// status register B bits and hour PM flag
	localparam int SB_BINARY = 2;
	localparam int SB_24H    = 1;
	localparam int HOUR_PM   = 7;

	localparam logic [YEAR_W-1:0] CENTURY       = 13'd100;
	localparam logic [31:0]       EPOCH_YEAR    = 32'd1970;
	localparam logic [31:0]       LEAP_BASE     = 32'd1969;
	localparam logic [31:0]       DAYS_PER_YEAR = 32'd365;
	localparam logic [31:0]       HOURS_PER_DAY = 32'd24;
	localparam logic [31:0]       SIXTY         = 32'd60;

	// year / 100 as a multiply by a scaled reciprocal, exact for 12-bit years
	localparam int CENT_PROD_W = 25;
	localparam logic [CENT_PROD_W-1:0] CENT_RECIP = 25'd5243;
	localparam int CENT_SHIFT = 19;

	localparam logic [7:0] MONTH_FIRST = 8'd1;
	localparam logic [7:0] MONTH_LAST  = 8'd12;
	localparam logic [7:0] MONTH_FEB   = 8'd2;

	typedef struct packed {
		logic [7:0] second;
		logic [7:0] minute;
		logic [7:0] hour;
		logic [7:0] day;
		logic [7:0] month;
		logic [7:0] year2;
	} rtcep_time_t;

	// days before the first of a month; months outside 1..12 add nothing
	function automatic logic [8:0] month_start(input logic [7:0] m);
		logic [8:0] r;
		case (m)
			8'd1:    r = 9'd0;
			8'd2:    r = 9'd31;
			8'd3:    r = 9'd59;
			8'd4:    r = 9'd90;
			8'd5:    r = 9'd120;
			8'd6:    r = 9'd151;
			8'd7:    r = 9'd181;
			8'd8:    r = 9'd212;
			8'd9:    r = 9'd243;
			8'd10:   r = 9'd273;
			8'd11:   r = 9'd304;
			8'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/rtcep_decode.sv -----
module rtcep_decode (
	input  logic [7:0]              raw_second,
	input  logic [7:0]              raw_minute,
	input  logic [7:0]              raw_hour,
	input  logic [7:0]              raw_day,
	input  logic [7:0]              raw_month,
	input  logic [7:0]              raw_year,
	input  logic [7:0]              status_b,
	output rtcep_pkg::rtcep_time_t  dec
);

	// no digit check: a nibble above 9 still adds its value
	function automatic logic [7:0] bcd(input logic [7:0] v);
		return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
	endfunction

	// reduce a value below 140 modulo 24
	function automatic logic [7:0] mod24(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (r >= 8'd24) begin
				r = r - 8'd24;
			end
		end
		return r;
	endfunction

	logic       is_bin;
	logic [7:0] hr_bcd;
	logic [7:0] hr_sel;

	assign is_bin = status_b[rtcep_pkg::SB_BINARY];
	// hour tens digit is bits 6..4 only; keep PM bit
	assign hr_bcd = (8'(raw_hour[3:0]) + 8'(raw_hour[6:4]) * 8'd10)
		| {raw_hour[rtcep_pkg::HOUR_PM], 7'b0};
	assign hr_sel = is_bin ? raw_hour : hr_bcd;

	always_comb begin
		dec.second = is_bin ? raw_second : bcd(raw_second);
		dec.minute = is_bin ? raw_minute : bcd(raw_minute);
		dec.day    = is_bin ? raw_day    : bcd(raw_day);
		dec.month  = is_bin ? raw_month  : bcd(raw_month);
		dec.year2  = is_bin ? raw_year   : bcd(raw_year);
		if (!status_b[rtcep_pkg::SB_24H] && hr_sel[rtcep_pkg::HOUR_PM]) begin
			dec.hour = mod24({1'b0, hr_sel[6:0]} + 8'd12);
		end else begin
			dec.hour = hr_sel;
		end
	end

endmodule

// ----- sv/rtc_fields_to_epoch_seconds.sv -----
// CMOS RTC register bytes to seconds since 1970-01-01.
//
// Command side: present the seven register bytes (raw_second .. raw_year and
// status_b) with start high; a word is taken at every edge where start is high
// and busy is low. busy is always low: a new word may enter every cycle.
// Result side: done is high for exactly one cycle with the decoded calendar
// fields, the corrected full_year, bad_month and epoch_seconds. The receiver
// cannot hold results off, and none is needed: the pipeline never stalls.
// Throughput is one word per cycle. The seven stages are: byte decode and
// century quotient, century add, year/leap/month terms, day sum, then one
// multiply-add each for hours, minutes and seconds.
// Configuration: cfg_wr_en with cfg_wr_data writes the reference year register
// (resets to 2024). Write it only while no word is in flight; a word takes the
// value it sees on entry.
// Reset (arst_n low) clears all valid bits and drops words in flight.
module rtc_fields_to_epoch_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  raw_second,
	input  logic [7:0]  raw_minute,
	input  logic [7:0]  raw_hour,
	input  logic [7:0]  raw_day,
	input  logic [7:0]  raw_month,
	input  logic [7:0]  raw_year,
	input  logic [7:0]  status_b,
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data,
	output logic        done,
	output logic [31:0] epoch_seconds,
	output logic [15:0] full_year,
	output logic [7:0]  month_out,
	output logic [7:0]  day_out,
	output logic [7:0]  hour_out,
	output logic [7:0]  minute_out,
	output logic [7:0]  second_out,
	output logic        bad_month
);

	localparam int YW = rtcep_pkg::YEAR_W;

	logic [rtcep_pkg::CY_W-1:0] cy_q;

	rtcep_pkg::rtcep_time_t dec;

	rtcep_decode u_decode (
		.raw_second (raw_second),
		.raw_minute (raw_minute),
		.raw_hour   (raw_hour),
		.raw_day    (raw_day),
		.raw_month  (raw_month),
		.raw_year   (raw_year),
		.status_b   (status_b),
		.dec        (dec)
	);

	// valid bits, one per stage
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	// fields riding along
	rtcep_pkg::rtcep_time_t dec_s1, dec_s2, dec_s3, dec_s4, dec_s5, dec_s6, dec_s7;
	logic [rtcep_pkg::CY_W-1:0]   cy_s1;
	logic [rtcep_pkg::CENT_W-1:0] cent_s1;
	logic [YW-1:0] year_s2, year_s3, year_s4, year_s5, year_s6, year_s7;
	logic bad_s2, bad_s3, bad_s4, bad_s5, bad_s6, bad_s7;

	// arithmetic terms
	logic [31:0] yprod_s3, leaps_s3, mday_s3;
	logic [31:0] days_s4, hours_s5, mins_s6, secs_s7;

	// combinational per stage
	logic [rtcep_pkg::CENT_PROD_W-1:0] cent_prod;
	logic [YW-1:0] base_c, ysum_c, year_c;
	logic          bad_c;
	logic [31:0]   yprod_c, leaps_c, mday_c;

	assign busy = 1'b0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cy_q <= 12'd2024;
		end else if (cfg_wr_en) begin
			cy_q <= cfg_wr_data;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// stage 1: century quotient of the reference year
	assign cent_prod = rtcep_pkg::CENT_PROD_W'(cy_q) * rtcep_pkg::CENT_RECIP;

	// stage 2: widen the two-digit year, push it past the reference year; flag bad months
	assign base_c = YW'(cent_s1) * rtcep_pkg::CENTURY;
	assign ysum_c = YW'(dec_s1.year2) + base_c;
	assign year_c = (ysum_c < YW'(cy_s1)) ? ysum_c + rtcep_pkg::CENTURY : ysum_c;
	assign bad_c  = !(dec_s1.month inside
		{[rtcep_pkg::MONTH_FIRST:rtcep_pkg::MONTH_LAST]});

	// stage 3: year days, leap days, days within the year (all wrap at 2^32)
	assign yprod_c = (32'(year_s2) - rtcep_pkg::EPOCH_YEAR) * rtcep_pkg::DAYS_PER_YEAR;
	assign leaps_c = (32'(year_s2) - rtcep_pkg::LEAP_BASE
		+ 32'(dec_s2.month > rtcep_pkg::MONTH_FEB)) >> 2;
	assign mday_c  = (bad_s2 ? 32'd0 : 32'(rtcep_pkg::month_start(dec_s2.month)))
		+ 32'(dec_s2.day) - 32'd1;

	always_ff @(posedge clk) begin
		dec_s1   <= dec;
		cy_s1    <= cy_q;
		cent_s1  <= cent_prod[rtcep_pkg::CENT_SHIFT +: rtcep_pkg::CENT_W];

		dec_s2   <= dec_s1;
		year_s2  <= year_c;
		bad_s2   <= bad_c;

		dec_s3   <= dec_s2;
		year_s3  <= year_s2;
		bad_s3   <= bad_s2;
		yprod_s3 <= yprod_c;
		leaps_s3 <= leaps_c;
		mday_s3  <= mday_c;

		dec_s4   <= dec_s3;
		year_s4  <= year_s3;
		bad_s4   <= bad_s3;
		days_s4  <= yprod_s3 + leaps_s3 + mday_s3;

		dec_s5   <= dec_s4;
		year_s5  <= year_s4;
		bad_s5   <= bad_s4;
		hours_s5 <= days_s4 * rtcep_pkg::HOURS_PER_DAY + 32'(dec_s4.hour);

		dec_s6   <= dec_s5;
		year_s6  <= year_s5;
		bad_s6   <= bad_s5;
		mins_s6  <= hours_s5 * rtcep_pkg::SIXTY + 32'(dec_s5.minute);

		dec_s7   <= dec_s6;
		year_s7  <= year_s6;
		bad_s7   <= bad_s6;
		secs_s7  <= mins_s6 * rtcep_pkg::SIXTY + 32'(dec_s6.second);
	end

	// drive the result word straight from the last stage
	assign done          = valid_s7;
	assign epoch_seconds = secs_s7;
	assign full_year     = 16'(year_s7);
	assign month_out     = dec_s7.month;
	assign day_out       = dec_s7.day;
	assign hour_out      = dec_s7.hour;
	assign minute_out    = dec_s7.minute;
	assign second_out    = dec_s7.second;
	assign bad_month     = bad_s7;

	// every accepted word comes out as a result word from the last stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("result word missing seven cycles after accept");

	// no result word without a matching accepted word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result word without matching accept");

	// flag must match the month delivered with it
	a_bad_month: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bad_month == ((month_out < rtcep_pkg::MONTH_FIRST)
			|| (month_out > rtcep_pkg::MONTH_LAST))))
		else $error("bad_month disagrees with month_out");

endmodule
